// ===== rtl/core/lowercase_word_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lowercase word tokenizer
// Clocked assertion shorthands, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef LOWERCASE_WORD_TOKENIZER_MACROS_SVH
`define LOWERCASE_WORD_TOKENIZER_MACROS_SVH

// Property checked at every rising edge, skipped while rst is high.
`define LWT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, including cycles in reset.
`define LWT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Lowercase word tokenizer package
// Shared constants, beat type and character-class helpers.
// ----------------------------------------------------------------------------
package lwt_pkg;

  // Default minimum word length (legal range 1 to 8).
  localparam int MIN_LEN_DEFAULT = 3;

  // One output beat.
  typedef struct packed {
    logic       word_last;
    logic [7:0] word_byte;
  } beat_t;

  // ASCII 0-9, A-Z, a-z; everything else (including 128 and up) separates.
  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return is_upper(c) ? (c | 8'h20) : c;
  endfunction

endpackage

// ===== rtl/core/lowercase_word_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Lowercase word tokenizer
// Splits a byte stream into lowercased alphanumeric words of at least
// MIN_LEN characters and streams them out, one byte per beat.
// ----------------------------------------------------------------------------
// Text enters one byte per beat on the s_ side, s_tlast marking the final
// byte of the text. Letters and digits form words and leave lowercased; any
// other byte (including 128 and above) ends the current word. Words shorter
// than MIN_LEN are dropped; all others pass through whole, m_tlast marking
// each word's last byte. The block accepts one byte per cycle indefinitely
// while the output side keeps up. Each accepted beat is held in an input
// register, then a single combinational pass writes its results
// (0 to MIN_LEN beats, 2 for MIN_LEN of 1) into an output queue of
// 2**clog2(2*(HOLD+1)) entries (8 at MIN_LEN=3); results are registered in
// the queue and offered from its head. The input stalls only while the
// queue has fewer than HOLD+1 free entries, i.e. when the output side is
// slower than the burst rate at word ends.
module lowercase_word_tokenizer #(
  parameter int MIN_LEN = lwt_pkg::MIN_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // text input
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // text_end
  // word output
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] word_byte
  output logic       m_tlast    // word_last
);

  // Newest bytes of the current word kept back; at least one for the end mark.
  localparam int HOLD = (MIN_LEN > 1) ? MIN_LEN - 1 : 1;
  localparam int CW   = $clog2(MIN_LEN + 1);
  localparam int QD   = 2 ** $clog2(2 * (HOLD + 1));
  localparam int QAW  = $clog2(QD);
  localparam int LW   = QAW + 1;

  localparam logic [CW-1:0] MIN_C   = CW'(MIN_LEN);
  localparam logic [CW-1:0] HOLD_C  = CW'(HOLD);
  localparam logic [LW-1:0] ROOM_C  = LW'(QD - (HOLD + 1));
  localparam logic [LW-1:0] HOLD_LW = LW'(HOLD);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;

  // word state
  logic [7:0]    held [HOLD];
  logic [CW-1:0] word_count;

  // output queue
  lwt_pkg::beat_t queue [QD];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [LW-1:0]  level;

  // single pass
  logic           proc;
  logic           pop;
  logic           wc;
  logic [7:0]     lc;
  logic           full;
  logic [CW-1:0]  cnt_inc;
  logic [7:0]     held_next [HOLD];
  logic [7:0]     fl [HOLD];
  logic           emit0;
  logic           flush;
  logic           word_done;
  logic [LW-1:0]  wr_cnt;
  lwt_pkg::beat_t res [HOLD + 1];

  assign proc     = in_valid && (level <= ROOM_C);
  assign s_tready = !in_valid || proc;
  assign pop      = m_tvalid && m_tready;

  always_comb begin
    wc      = lwt_pkg::is_word_char(in_byte);
    lc      = lwt_pkg::to_lower(in_byte);
    full    = (word_count >= HOLD_C);
    cnt_inc = (word_count == MIN_C) ? word_count : word_count + CW'(1);

    // window update: shift in when full, else append at the fill point
    for (int i = 0; i < HOLD - 1; i++) begin
      if (full) begin
        held_next[i] = held[i + 1];
      end else begin
        held_next[i] = (word_count == CW'(i)) ? lc : held[i];
      end
    end
    if (full) begin
      held_next[HOLD - 1] = lc;
    end else begin
      held_next[HOLD - 1] = (word_count == CW'(HOLD - 1)) ? lc : held[HOLD - 1];
    end

    // a word char with a full window releases its oldest byte
    emit0     = wc && full;
    word_done = !wc || in_end;
    for (int i = 0; i < HOLD; i++) begin
      fl[i] = wc ? held_next[i] : held[i];
    end
    // a qualifying word always flushes exactly HOLD bytes
    flush  = word_done && ((wc ? cnt_inc : word_count) == MIN_C);
    wr_cnt = LW'(emit0) + (flush ? HOLD_LW : '0);

    res[0].word_byte = emit0 ? held[0] : fl[0];
    res[0].word_last = flush && !emit0 && (HOLD == 1);
    for (int j = 1; j < HOLD; j++) begin
      res[j].word_byte = emit0 ? fl[j - 1] : fl[j];
      res[j].word_last = flush && !emit0 && (j == HOLD - 1);
    end
    res[HOLD].word_byte = fl[HOLD - 1];
    res[HOLD].word_last = flush && emit0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (proc) begin
      word_count <= word_done ? '0 : cnt_inc;
    end
    if (proc && wc) begin
      held <= held_next;
    end
  end

  // queue: up to HOLD+1 writes at consecutive slots, one read at the head
  always_ff @(posedge clk) begin
    for (int j = 0; j <= HOLD; j++) begin
      if (proc && (LW'(j) < wr_cnt)) begin
        queue[wptr + QAW'(j)] <= res[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (proc) begin
        wptr <= wptr + wr_cnt[QAW-1:0];
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      level <= level + (proc ? wr_cnt : '0) - LW'(pop);
    end
  end

  assign m_tvalid = (level != '0);
  assign m_tdata  = queue[rptr].word_byte;
  assign m_tlast  = queue[rptr].word_last;

endmodule

// ===== rtl/core/lwt_checker.sv =====
// ----------------------------------------------------------------------------
// Lowercase word tokenizer checker
// Port-level assertions, bound to every tokenizer instance.
// ----------------------------------------------------------------------------
`include "lowercase_word_tokenizer_macros.svh"

module lwt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic m_stall;
  logic out_ok;

  assign m_stall = m_tvalid && !m_tready;
  assign out_ok  = lwt_pkg::is_word_char(m_tdata) && !lwt_pkg::is_upper(m_tdata);

  // stalled output beat stays offered
  `LWT_ASSERT(a_hold_valid, clk, rst, m_stall |=> m_tvalid, "m_tvalid dropped")

  // stalled output beat keeps its payload
  `LWT_ASSERT(a_hold_data, clk, rst, m_stall |=> $stable({m_tlast, m_tdata}), "payload changed")

  // queue is empty right after reset
  `LWT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")

  // input register is empty right after reset
  `LWT_ASSERT_ALWAYS(a_reset_ready, clk, rst |=> s_tready, "input not ready after reset")

  // only lowercased word characters leave the block
  `LWT_ASSERT(a_lower_word, clk, rst, m_tvalid |-> out_ok, "bad output byte")

endmodule

bind lowercase_word_tokenizer lwt_checker u_lwt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
